>>> sv/uartrx_pkg.sv
`timescale 1ns / 1ps

package uartrx_pkg;

    // Host and line actions carried by an input transaction
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_FLUSH = 2'd3
    } rx_action_t;

    // Configuration register indexes
    localparam logic [1:0] REG_BIT_PERIOD  = 2'd0;
    localparam logic [1:0] REG_START_DELAY = 2'd1;
    localparam logic [1:0] REG_RX_ENABLE   = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] BIT_PERIOD_RST  = 16'd7500;
    localparam logic [CFG_DATA_W-1:0] START_DELAY_RST = 16'd10950;

    // Character phases: 0..7 sample data bits, COMMIT stores the byte
    localparam logic [3:0] PHASE_COMMIT = 4'd8;
    localparam logic [3:0] PHASE_IDLE   = 4'd9;

    typedef struct packed {
        rx_action_t action;
        logic       rx_level;
    } rx_in_t;

    typedef struct packed {
        logic [7:0] data;
        logic       data_valid;
        logic [7:0] fill_count;
        logic       overflow;
        logic       receiving;
    } rx_out_t;

    // Status of one transaction, minus the byte that the memory returns
    typedef struct packed {
        logic       data_valid;
        logic [7:0] fill_count;
        logic       overflow;
        logic       receiving;
    } rx_status_t;

endpackage

>>> sv/uartrx_ram.sv
`timescale 1ns / 1ps

module uartrx_ram #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/uartrx_ctrl.sv
`timescale 1ns / 1ps

module uartrx_ctrl #(
    parameter int DEPTH = 64,
    parameter int TIMER_BITS = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [uartrx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [uartrx_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              accept,
    input  uartrx_pkg::rx_in_t                item,
    output logic                              wr_en,
    output logic [AW-1:0]                     wr_addr,
    output logic [7:0]                        wr_data,
    output logic [AW-1:0]                     rd_addr,
    output uartrx_pkg::rx_status_t            status
);

    import uartrx_pkg::*;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [CFG_DATA_W-1:0] bit_period_reg;
    logic [CFG_DATA_W-1:0] start_delay_reg;
    logic                  rx_enable_reg;

    logic [AW-1:0]         wr_idx_reg,   wr_idx_next;
    logic [AW-1:0]         rd_idx_reg,   rd_idx_next;
    logic                  overflow_reg, overflow_next;
    logic [3:0]            phase_reg,    phase_next;
    logic [TIMER_BITS-1:0] count_reg,    count_next;
    logic [7:0]            shift_reg,    shift_next;
    logic                  last_reg,     last_next;

    logic [AW-1:0]         wr_inc;
    logic [AW-1:0]         rd_inc;
    logic                  fifo_empty;
    logic                  commit;
    logic [AW:0]           fill;

    assign wr_inc     = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + AW'(1);
    assign rd_inc     = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + AW'(1);
    assign fifo_empty = (rd_idx_reg == wr_idx_reg);

    always_comb
    begin
        wr_idx_next   = wr_idx_reg;
        rd_idx_next   = rd_idx_reg;
        overflow_next = overflow_reg;
        phase_next    = phase_reg;
        count_next    = count_reg;
        shift_next    = shift_reg;
        last_next     = last_reg;
        commit        = 1'b0;
        status.data_valid = 1'b0;

        unique case (item.action)
            ACT_TICK:
            begin
                last_next = item.rx_level;
                if (phase_reg == PHASE_IDLE)
                begin
                    // start edge: line was high, now low
                    if (rx_enable_reg && last_reg && !item.rx_level)
                    begin
                        count_next = TIMER_BITS'(start_delay_reg);
                        phase_next = 4'd0;
                    end
                end
                else if (count_reg > TIMER_BITS'(1))
                begin
                    count_next = count_reg - TIMER_BITS'(1);
                end
                else if (phase_reg < PHASE_COMMIT)
                begin
                    shift_next = {item.rx_level, shift_reg[7:1]};
                    count_next = TIMER_BITS'(bit_period_reg);
                    phase_next = phase_reg + 4'd1;
                end
                else
                begin
                    count_next = '0;
                    phase_next = PHASE_IDLE;
                    if (wr_inc != rd_idx_reg)
                    begin
                        commit      = 1'b1;
                        wr_idx_next = wr_inc;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
            end
            ACT_POP,
            ACT_PEEK:
            begin
                if (rx_enable_reg && !fifo_empty)
                begin
                    status.data_valid = 1'b1;
                    if (item.action == ACT_POP)
                    begin
                        rd_idx_next = rd_inc;
                    end
                end
            end
            ACT_FLUSH:
            begin
                wr_idx_next = '0;
                rd_idx_next = '0;
            end
        endcase

        // occupancy after this transaction, modulo the store depth
        if (wr_idx_next >= rd_idx_next)
        begin
            fill = {1'b0, wr_idx_next} - {1'b0, rd_idx_next};
        end
        else
        begin
            fill = {1'b0, wr_idx_next} + (AW + 1)'(DEPTH) - {1'b0, rd_idx_next};
        end

        status.fill_count = rx_enable_reg ? 8'(fill) : 8'd0;
        status.overflow   = overflow_next;
        status.receiving  = (phase_next != PHASE_IDLE);
    end

    assign wr_en   = accept && commit;
    assign wr_addr = wr_idx_reg;
    assign wr_data = shift_reg;
    assign rd_addr = rd_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg  <= BIT_PERIOD_RST;
            start_delay_reg <= START_DELAY_RST;
            rx_enable_reg   <= 1'b1;
            wr_idx_reg      <= '0;
            rd_idx_reg      <= '0;
            overflow_reg    <= 1'b0;
            phase_reg       <= PHASE_IDLE;
            count_reg       <= '0;
            shift_reg       <= '0;
            last_reg        <= 1'b1;
        end
        else if (cfg_write)
        begin
            // the user must send configuration only while no transaction is in flight; unchecked here
            unique case (cfg_index)
                REG_BIT_PERIOD:  bit_period_reg  <= cfg_data;
                REG_START_DELAY: start_delay_reg <= cfg_data;
                REG_RX_ENABLE:
                begin
                    if (cfg_data[0] && !rx_enable_reg)
                    begin
                        wr_idx_reg   <= '0;
                        rd_idx_reg   <= '0;
                        overflow_reg <= 1'b0;
                    end
                    rx_enable_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            wr_idx_reg   <= wr_idx_next;
            rd_idx_reg   <= rd_idx_next;
            overflow_reg <= overflow_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            shift_reg    <= shift_next;
            last_reg     <= last_next;
        end
    end

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_IDLE)
        else $error("bit phase out of range");

    a_no_full_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_inc != rd_idx_reg))
        else $error("byte stored into a full fifo");

    a_start_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PHASE_IDLE && phase_next != PHASE_IDLE)
        |-> rx_enable_reg)
        else $error("character started while disabled");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (overflow_reg && !cfg_write) |=> overflow_reg)
        else $error("overflow flag dropped without re-enable");
`endif

endmodule

>>> sv/uart_receiver_with_fifo.sv
`timescale 1ns / 1ps

// 8N1 serial receiver with a receive fifo. Each input transaction is either a
// timer tick carrying the sampled line level, or a host pop, peek or flush;
// every input transaction yields exactly one result transaction holding the
// head byte (pop/peek), the fill count, the sticky overflow flag and the
// receiving status. A falling line edge while idle and enabled loads the
// down-counter with start_delay; each expiry samples one data bit LSB first
// and reloads bit_period, and the expiry after the eighth bit stores the byte
// or, with FIFO_DEPTH-1 bytes held, drops it and sets overflow. The stop bit
// is not checked. Rate: one transaction per clock while result_ready is high;
// a low result_ready stalls input. A result passes the read stage, where the
// byte store read returns, and then the output register. The receiver state is
// updated in the accept cycle, so consecutive transactions need no forwarding.
// Configuration writes take effect at once and belong in idle periods;
// raising rx_enable from 0 empties the fifo and clears overflow.

module uart_receiver_with_fifo #(
    parameter int FIFO_DEPTH = 64,
    parameter int TIMER_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [uartrx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [uartrx_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  uartrx_pkg::rx_in_t                 item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output uartrx_pkg::rx_out_t                result
);

    import uartrx_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    logic          accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    rx_status_t    status;

    // Read stage: status waits here while the store returns the head byte
    logic          s1_valid_reg;
    rx_status_t    s1_status_reg;
    logic          s1_move;

    // Output register
    logic          out_valid_reg;
    rx_out_t       out_reg;

    // Advance the read stage whenever the output register is free or drains
    assign s1_move    = s1_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || s1_move;
    assign accept     = item_valid && item_ready;

    uartrx_ctrl #(
        .DEPTH      (FIFO_DEPTH),
        .TIMER_BITS (TIMER_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (item),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .status    (status)
    );

    // Read the head entry on every accepted transaction; hold it while stalled
    uartrx_ram #(
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            // drop the stored byte unless the pop or peek found one
            out_reg.data       <= s1_status_reg.data_valid ? rd_data : 8'd0;
            out_reg.data_valid <= s1_status_reg.data_valid;
            out_reg.fill_count <= s1_status_reg.fill_count;
            out_reg.overflow   <= s1_status_reg.overflow;
            out_reg.receiving  <= s1_status_reg.receiving;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result)))
        else $error("result changed while stalled");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !result_ready) |-> !item_ready)
        else $error("transaction accepted with both stages blocked");

    a_empty_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.data_valid) |-> (result.data == 8'd0))
        else $error("byte returned without a successful pop or peek");
`endif

endmodule
